>>> sv/ppc_pkg.sv
// Shared types, widths and codes of the polygon area, perimeter and convexity core.
// Depends on nothing; every other file imports it.
package ppc_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int COORD_W      = 24;
   localparam int DIFF_W       = COORD_W + 1;
   localparam int PROD_W       = 2 * DIFF_W;
   localparam int CROSS_W      = PROD_W + 1;
   localparam int AREA_ACC_W   = 64;
   localparam int AREA_W       = 59;
   localparam int PERIM_W      = 36;
   localparam int CNT_W        = 11;
   localparam int ROOT_W       = 26;
   localparam int RAD_W        = 2 * ROOT_W;
   localparam int REM_W        = ROOT_W + 3;
   localparam int STEP_W       = 5;
   localparam int Q_DEPTH      = 4;
   localparam int Q_PTR_W      = 2;

   typedef struct packed {
      logic signed [COORD_W-1:0] vertex_x;
      logic signed [COORD_W-1:0] vertex_y;
      logic                      last_vertex;
   } req_item_type;

   typedef struct packed {
      logic [AREA_W-1:0]  area_abs;
      logic [PERIM_W-1:0] perimeter_len;
      logic               is_convex;
      logic [CNT_W-1:0]   vertex_count;
      logic               too_many;
   } rsp_item_type;

   typedef enum logic [1:0] {
      VK_FIRST,
      VK_SECOND,
      VK_LATER
   } vkind_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } pt_type;

   typedef struct packed {
      pt_type           pt;
      logic             last;
      logic             keep;
      vkind_type        kind;
      logic [CNT_W-1:0] n;
      logic             ovf;
   } q_entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_EDGE_MUL,
      ST_SQ_GO,
      ST_SQ_WAIT,
      ST_AREA_MUL,
      ST_AREA_ADD,
      ST_TURN_MUL,
      ST_TURN_CHK,
      ST_ADVANCE,
      ST_CLOSE,
      ST_CT1_MUL,
      ST_CT1_CHK,
      ST_CT2_MUL,
      ST_CT2_CHK,
      ST_OUT
   } back_state_type;

endpackage

>>> sv/polygon_area_perimeter_convexity_core.sv
// Top level of the polygon area, perimeter and convexity core.
// Depends on ppc_pkg, ppc_front, ppc_queue and ppc_back.
//
// Use: send the vertices of a closed polygon on the req_ channel, one item per
// vertex, with last_vertex set on the final one. Coordinates are signed with
// 8 fraction bits. One result item per polygon leaves on the rsp_ channel:
// absolute shoelace area (16 fraction bits), perimeter as a sum of floor edge
// lengths, a convexity flag, the vertex count (saturating at MAX_VERTICES)
// and a flag for vertices beyond that bound, which are dropped.
//
// Timing: the front accepts an item in any cycle the four-entry queue has
// room. The back sequencer dispatches and advances the first vertex; the
// second adds the edge squares and the 26-step square root, whose
// iterations dominate, and each later one adds area and turn products.
// Closing a polygon of three or more vertices adds the closing edge and both
// turn checks (two vertices: edge only; one: neither), then loads the result
// register once the slot is free. A dropped vertex skips all arithmetic.
//
// Reset clears the vertex count, accumulators and queue; no result is pending.
// A stalled result holds in its register; the back part stops only at the
// next result, and the front keeps filling the queue until it is full.
module polygon_area_perimeter_convexity_core import ppc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   q_entry_type push_entry, pop_entry;
   logic        q_push, q_full, q_pop, q_not_empty;

   // Front: tag each vertex with its position and running count.
   ppc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (push_entry)
   );

   // Queue: decouple the front from the slow back sequencer.
   ppc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .pop_entry  (pop_entry)
   );

   // Back: accumulate and deliver one result per polygon.
   ppc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_not_empty),
      .q_entry   (pop_entry),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

>>> sv/ppc_front.sv
// Front part: accepts vertices, counts them per polygon and tags each for the back part.
// Depends on ppc_pkg.
module ppc_front import ppc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   input  logic         q_full,
   output logic         q_push,
   output q_entry_type  q_entry
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic             keep;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign keep      = count_ff < CNT_W'(MAX_VERTICES);

   always_comb begin
      q_entry.pt.x = req_item.vertex_x;
      q_entry.pt.y = req_item.vertex_y;
      q_entry.last = req_item.last_vertex;
      q_entry.keep = keep;
      if (count_ff == CNT_W'(0)) begin
         q_entry.kind = VK_FIRST;
      end else if (count_ff == CNT_W'(1)) begin
         q_entry.kind = VK_SECOND;
      end else begin
         q_entry.kind = VK_LATER;
      end
      q_entry.n   = keep ? count_ff + CNT_W'(1) : count_ff;
      q_entry.ovf = ovf_ff | !keep;
   end

   // Start over after the last vertex of a polygon.
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (q_push) begin
         if (req_item.last_vertex) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end else begin
            count_in = q_entry.n;
            ovf_in   = q_entry.ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

>>> sv/ppc_queue.sv
// Short register queue between the front and back parts.
// Depends on ppc_pkg.
module ppc_queue import ppc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  q_entry_type push_entry,
   output logic        full,
   input  logic        pop,
   output logic        not_empty,
   output q_entry_type pop_entry
);

   q_entry_type        mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [Q_PTR_W:0]   fill_ff, fill_in;

   assign full      = fill_ff == (Q_PTR_W+1)'(Q_DEPTH);
   assign not_empty = fill_ff != '0;
   assign pop_entry = mem_ff[rd_ff];

   always_comb begin
      wr_in   = push ? wr_ff + Q_PTR_W'(1) : wr_ff;
      rd_in   = pop ? rd_ff + Q_PTR_W'(1) : rd_ff;
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + (Q_PTR_W+1)'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - (Q_PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty) else $error("pop from empty queue");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= (Q_PTR_W+1)'(Q_DEPTH)) else $error("queue fill beyond depth");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (fill_ff != (Q_PTR_W+1)'(Q_DEPTH)) |-> (wr_ff - rd_ff) == fill_ff[Q_PTR_W-1:0])
      else $error("queue pointers disagree with fill");

endmodule

>>> sv/ppc_sqrt.sv
// Iterative floor square root, two radicand bits per cycle.
// Depends on ppc_pkg.
module ppc_sqrt import ppc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAD_W-1:0]  radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in, rem_sh, trial;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in, done_ff, done_in;

   assign done   = done_ff;
   assign root   = root_ff;
   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

endmodule

>>> sv/ppc_back.sv
// Back part: sequencer that accumulates area, perimeter and turn signs per vertex.
// Depends on ppc_pkg and ppc_sqrt.
module ppc_back import ppc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   input  q_entry_type  q_entry,
   output logic         q_pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   back_state_type state_ff, state_in;

   q_entry_type  cur_ff;
   pt_type       first_ff, second_ff, prev_ff, pp_ff;
   logic         closing_ff, closing_in;
   logic signed [AREA_ACC_W-1:0] area_ff;
   logic [PERIM_W-1:0] perim_ff;
   logic         ref_ff, ok_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;

   logic signed [PROD_W-1:0] p1_ff, p2_ff;
   pt_type       pa, pb, pc, pd;
   logic         sq_mode;
   logic signed [DIFF_W-1:0] ux, uy, vx, vy;
   logic signed [CROSS_W-1:0] cross_v;
   logic         turn_pos;
   logic [RAD_W-1:0]  sq_sum;
   logic              sq_start, sq_done;
   logic [ROOT_W-1:0] sq_root;
   logic [PERIM_W:0]  perim_sum;
   logic              slot_free;
   logic [AREA_ACC_W-1:0] area_mag;

   ppc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_sum),
      .done     (sq_done),
      .root     (sq_root)
   );

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign ux = DIFF_W'(pb.x) - DIFF_W'(pa.x);
   assign uy = DIFF_W'(pb.y) - DIFF_W'(pa.y);
   assign vx = DIFF_W'(pd.x) - DIFF_W'(pc.x);
   assign vy = DIFF_W'(pd.y) - DIFF_W'(pc.y);
   assign cross_v  = CROSS_W'(p1_ff) - CROSS_W'(p2_ff);
   assign turn_pos = (cross_v != '0) && !cross_v[CROSS_W-1];
   assign sq_sum   = RAD_W'($unsigned(p1_ff)) + RAD_W'($unsigned(p2_ff));
   assign perim_sum = {1'b0, perim_ff} + (PERIM_W+1)'(sq_root);
   assign area_mag  = area_ff[AREA_ACC_W-1] ? AREA_ACC_W'(-area_ff) : AREA_ACC_W'(area_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (q_valid) state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            if (!cur_ff.keep) begin
               state_in = cur_ff.last ? ST_CLOSE : ST_IDLE;
            end else if (cur_ff.kind == VK_FIRST) begin
               state_in = ST_ADVANCE;
            end else begin
               state_in = ST_EDGE_MUL;
            end
         end
         ST_EDGE_MUL: state_in = ST_SQ_GO;
         ST_SQ_GO:    state_in = ST_SQ_WAIT;
         ST_SQ_WAIT: begin
            if (sq_done) begin
               if (closing_ff) begin
                  state_in = (cur_ff.n >= CNT_W'(3)) ? ST_CT1_MUL : ST_OUT;
               end else begin
                  state_in = (cur_ff.kind == VK_LATER) ? ST_AREA_MUL : ST_ADVANCE;
               end
            end
         end
         ST_AREA_MUL: state_in = ST_AREA_ADD;
         ST_AREA_ADD: state_in = ST_TURN_MUL;
         ST_TURN_MUL: state_in = ST_TURN_CHK;
         ST_TURN_CHK: state_in = ST_ADVANCE;
         ST_ADVANCE:  state_in = cur_ff.last ? ST_CLOSE : ST_IDLE;
         ST_CLOSE:    state_in = (cur_ff.n >= CNT_W'(2)) ? ST_EDGE_MUL : ST_OUT;
         ST_CT1_MUL:  state_in = ST_CT1_CHK;
         ST_CT1_CHK:  state_in = ST_CT2_MUL;
         ST_CT2_MUL:  state_in = ST_CT2_CHK;
         ST_CT2_CHK:  state_in = ST_OUT;
         ST_OUT:      if (slot_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Outputs and operand selection.
   always_comb begin
      q_pop    = 1'b0;
      sq_start = 1'b0;
      sq_mode  = 1'b0;
      pa = prev_ff;
      pb = cur_ff.pt;
      pc = prev_ff;
      pd = cur_ff.pt;
      unique case (state_ff)
         ST_IDLE:     q_pop = q_valid;
         ST_EDGE_MUL: begin
            sq_mode = 1'b1;
            pa = closing_ff ? first_ff : cur_ff.pt;
            pb = prev_ff;
         end
         ST_SQ_GO:    sq_start = 1'b1;
         ST_AREA_MUL: begin
            pa = first_ff;
            pb = prev_ff;
            pc = first_ff;
            pd = cur_ff.pt;
         end
         ST_TURN_MUL: begin
            pa = pp_ff;
            pb = prev_ff;
            pc = prev_ff;
            pd = cur_ff.pt;
         end
         ST_CT1_MUL: begin
            pa = pp_ff;
            pb = prev_ff;
            pc = prev_ff;
            pd = first_ff;
         end
         ST_CT2_MUL: begin
            pa = prev_ff;
            pb = first_ff;
            pc = first_ff;
            pd = second_ff;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      closing_in = closing_ff;
      if (state_ff == ST_CLOSE) begin
         closing_in = 1'b1;
      end else if (state_ff == ST_OUT) begin
         closing_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (state_ff == ST_OUT && slot_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         closing_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         area_ff      <= '0;
         perim_ff     <= '0;
         ref_ff       <= 1'b0;
         ok_ff        <= 1'b1;
      end else begin
         state_ff     <= state_in;
         closing_ff   <= closing_in;
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            ST_SQ_WAIT: begin
               if (sq_done) begin
                  perim_ff <= perim_sum[PERIM_W] ? '1 : perim_sum[PERIM_W-1:0];
               end
            end
            ST_AREA_ADD: area_ff <= area_ff + AREA_ACC_W'(cross_v);
            ST_TURN_CHK: begin
               if (cur_ff.n == CNT_W'(3)) begin
                  ref_ff <= turn_pos;
               end else if (turn_pos != ref_ff) begin
                  ok_ff <= 1'b0;
               end
            end
            ST_CT1_CHK, ST_CT2_CHK: begin
               if (turn_pos != ref_ff) ok_ff <= 1'b0;
            end
            ST_OUT: begin
               if (slot_free) begin
                  area_ff  <= '0;
                  perim_ff <= '0;
                  ref_ff   <= 1'b0;
                  ok_ff    <= 1'b1;
               end
            end
            default: begin
               ok_ff <= ok_ff;
            end
         endcase
      end
   end

   // Datapath registers, no reset.
   always_ff @(posedge clock) begin
      p1_ff <= sq_mode ? ux * ux : ux * vy;
      p2_ff <= sq_mode ? uy * uy : uy * vx;
      if (q_pop) begin
         cur_ff <= q_entry;
      end
      if (state_ff == ST_ADVANCE) begin
         pp_ff   <= prev_ff;
         prev_ff <= cur_ff.pt;
         if (cur_ff.kind == VK_FIRST) first_ff <= cur_ff.pt;
         if (cur_ff.kind == VK_SECOND) second_ff <= cur_ff.pt;
      end
      if (state_ff == ST_OUT && slot_free) begin
         rsp_item_ff.area_abs      <= area_mag[AREA_W:1];
         rsp_item_ff.perimeter_len <= perim_ff;
         rsp_item_ff.is_convex     <= (cur_ff.n >= CNT_W'(3)) ? ok_ff : 1'b1;
         rsp_item_ff.vertex_count  <= cur_ff.n;
         rsp_item_ff.too_many      <= cur_ff.ovf;
      end
   end

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == ST_IDLE) else $error("pop outside idle");
   a_start_once: assert property (@(posedge clock) disable iff (reset)
      sq_start |=> state_ff == ST_SQ_WAIT) else $error("root start without wait");
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT) else $error("result out of sequence");

endmodule
